[sv/hrl_pkg.sv]
// hrl_pkg: types and constants shared by the hex record loader modules
// character codes, decode offsets, parser phases and the queue token
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hrl_pkg;

   // character codes and digit decode offsets
   localparam logic [7:0]  CHAR_COLON    = 8'd58;
   localparam logic [7:0]  CHAR_ZERO     = 8'd48;
   localparam logic [7:0]  CHAR_NINE     = 8'd57;
   localparam logic [7:0]  DIGIT_OFFSET  = 8'd48;
   localparam logic [7:0]  LETTER_OFFSET = 8'd55;

   // configuration reset and default queue depth
   localparam logic [15:0] LOWEST_ADDRESS_RESET = 16'h3000;
   localparam int          QUEUE_DEPTH_DEFAULT  = 2;

   // digit counts that close each header field
   localparam logic [1:0]  LEN_LAST_DIGIT  = 2'd1;
   localparam logic [1:0]  ADDR_LAST_DIGIT = 2'd3;
   localparam logic [1:0]  TYPE_LAST_DIGIT = 2'd1;

   // parser phase
   typedef enum logic [2:0] {
      PH_WAIT,
      PH_LEN,
      PH_ADDR,
      PH_TYPE,
      PH_DATA
   } hrl_phase_type;

   // classified character passed from front to back
   typedef struct packed {
      logic       colon;
      logic [3:0] nibble;
   } hrl_token_type;

endpackage

`default_nettype wire

[sv/hex_record_loader.sv]
// hex_record_loader: top level of the hex record loader
// ties front decode, token queue, back parser and the floor register together
// depends on hrl_pkg, hrl_front, hrl_queue, hrl_back
//
// usage
//   req_ channel: one ASCII character of hex text per transfer (req_hex_char)
//   rsp_ channel: one result per transfer, either a byte write
//     (rsp_write_address, rsp_write_data, rsp_is_end low) or the end marker
//     (rsp_is_end high, address and data zero)
//   csr_ channel: write of the address floor; always ready, takes effect at
//     the next character
//   a character is decoded in the front and queued; the back parser takes one
//   queued character a cycle while the result register is free or drains,
//   so one character is accepted every cycle; each is queued at its
//   transfer, and the parser step that takes it loads any result it causes
//   into the result register
//   throughput: one character per cycle, set by the single parser step
//   when the receiver stalls the result register holds, the parser stops and
//   the queue fills; req_ready falls once the QUEUE_DEPTH entries are taken
//   reset: parser waits for a record start, queue and result register empty,
//   floor returns to 0x3000; after the end marker all input is swallowed
`timescale 1ns / 1ps
`default_nettype none

module hex_record_loader #(
   parameter int QUEUE_DEPTH = hrl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_hex_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_write_address,
   output logic [7:0]       rsp_write_data,
   output logic             rsp_is_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_lowest_address
);

   hrl_pkg::hrl_token_type front_token;
   hrl_pkg::hrl_token_type queue_token;
   logic                   queue_valid;
   logic                   queue_ready;
   logic [15:0]            lowest_address_ff;

   // address floor register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_address_ff <= hrl_pkg::LOWEST_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         lowest_address_ff <= csr_lowest_address;
      end
   end

   hrl_front u_front (
      .hex_char (req_hex_char),
      .token    (front_token)
   );

   hrl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_token (front_token),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_token  (queue_token)
   );

   hrl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .lowest_address    (lowest_address_ff),
      .tok_valid         (queue_valid),
      .tok_ready         (queue_ready),
      .tok               (queue_token),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_is_end        (rsp_is_end)
   );

endmodule

`default_nettype wire

[sv/hrl_front.sv]
// hrl_front: classifies each accepted character as record start or hex nibble
// depends on hrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrl_front (
   input  wire logic [7:0]         hex_char,
   output hrl_pkg::hrl_token_type  token
);

   logic [7:0] letter_diff;
   logic [7:0] digit_diff;

   // decimal digits map to c-48, everything else to c-55, low four bits kept
   always_comb begin
      digit_diff   = hex_char - hrl_pkg::DIGIT_OFFSET;
      letter_diff  = hex_char - hrl_pkg::LETTER_OFFSET;
      token.colon  = (hex_char == hrl_pkg::CHAR_COLON);
      if (hex_char inside {[hrl_pkg::CHAR_ZERO:hrl_pkg::CHAR_NINE]}) begin
         token.nibble = digit_diff[3:0];
      end else begin
         token.nibble = letter_diff[3:0];
      end
   end

endmodule

`default_nettype wire

[sv/hrl_queue.sv]
// hrl_queue: short first-in first-out queue of tokens between front and back
// depends on hrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrl_queue #(
   parameter int DEPTH = hrl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire hrl_pkg::hrl_token_type push_token,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output hrl_pkg::hrl_token_type      pop_token
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   hrl_pkg::hrl_token_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_token  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

[sv/hrl_back.sv]
// hrl_back: record parser state machine and result register
// takes one token a cycle from the queue unless the result stalls; depends on hrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrl_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [15:0]            lowest_address,
   input  wire logic                   tok_valid,
   output logic                        tok_ready,
   input  wire hrl_pkg::hrl_token_type tok,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [15:0]                 rsp_write_address,
   output logic [7:0]                  rsp_write_data,
   output logic                        rsp_is_end
);

   hrl_pkg::hrl_phase_type phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [15:0] record_address_ff, record_address_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  bytes_done_ff, bytes_done_in;
   logic        finished_ff, finished_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_address_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_end_ff;

   logic        pop;
   logic [7:0]  length_next;
   logic [7:0]  bytes_next;
   logic        emit_valid;
   logic [15:0] emit_address;
   logic [7:0]  emit_data;
   logic        emit_end;

   // a token is taken whenever the result slot is free or being drained
   assign pop       = tok_valid && (!rsp_valid_ff || rsp_ready);
   assign tok_ready = (!rsp_valid_ff || rsp_ready);

   assign length_next = {record_length_ff[3:0], tok.nibble};
   assign bytes_next  = bytes_done_ff + 8'd1;

   // next state
   always_comb begin
      phase_in          = phase_ff;
      digit_count_in    = digit_count_ff;
      record_length_in  = record_length_ff;
      record_address_in = record_address_ff;
      high_nibble_in    = high_nibble_ff;
      bytes_done_in     = bytes_done_ff;
      finished_in       = finished_ff;
      if (pop && !finished_ff) begin
         if (tok.colon) begin
            phase_in          = hrl_pkg::PH_LEN;
            digit_count_in    = '0;
            record_length_in  = '0;
            record_address_in = '0;
            high_nibble_in    = '0;
            bytes_done_in     = '0;
         end else begin
            case (phase_ff)
               hrl_pkg::PH_LEN: begin
                  record_length_in = length_next;
                  digit_count_in   = digit_count_ff + 2'd1;
                  if (digit_count_ff == hrl_pkg::LEN_LAST_DIGIT) begin
                     digit_count_in = '0;
                     if (length_next == 8'd0) begin
                        finished_in = 1'b1;
                        phase_in    = hrl_pkg::PH_WAIT;
                     end else begin
                        phase_in    = hrl_pkg::PH_ADDR;
                     end
                  end
               end
               hrl_pkg::PH_ADDR: begin
                  record_address_in = {record_address_ff[11:0], tok.nibble};
                  digit_count_in    = digit_count_ff + 2'd1;
                  if (digit_count_ff == hrl_pkg::ADDR_LAST_DIGIT) begin
                     digit_count_in = '0;
                     phase_in       = hrl_pkg::PH_TYPE;
                  end
               end
               hrl_pkg::PH_TYPE: begin
                  digit_count_in = digit_count_ff + 2'd1;
                  if (digit_count_ff == hrl_pkg::TYPE_LAST_DIGIT) begin
                     digit_count_in = '0;
                     phase_in       = hrl_pkg::PH_DATA;
                  end
               end
               hrl_pkg::PH_DATA: begin
                  if (digit_count_ff == 2'd0) begin
                     high_nibble_in = tok.nibble;
                     digit_count_in = 2'd1;
                  end else begin
                     digit_count_in = '0;
                     bytes_done_in  = bytes_next;
                     if (bytes_next == record_length_ff) begin
                        phase_in = hrl_pkg::PH_WAIT;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // outputs of the parser: end marker or data byte write
   always_comb begin
      emit_valid   = 1'b0;
      emit_end     = 1'b0;
      emit_address = '0;
      emit_data    = '0;
      if (pop && !finished_ff && !tok.colon) begin
         case (phase_ff)
            hrl_pkg::PH_LEN: begin
               if (digit_count_ff == hrl_pkg::LEN_LAST_DIGIT && length_next == 8'd0) begin
                  emit_valid = 1'b1;
                  emit_end   = 1'b1;
               end
            end
            hrl_pkg::PH_DATA: begin
               if (digit_count_ff != 2'd0 && record_address_ff >= lowest_address) begin
                  emit_valid   = 1'b1;
                  emit_address = record_address_ff + {8'd0, bytes_done_ff};
                  emit_data    = {high_nibble_ff, tok.nibble};
               end
            end
            default: begin
               emit_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= hrl_pkg::PH_WAIT;
         digit_count_ff    <= '0;
         record_length_ff  <= '0;
         record_address_ff <= '0;
         high_nibble_ff    <= '0;
         bytes_done_ff     <= '0;
         finished_ff       <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         digit_count_ff    <= digit_count_in;
         record_length_ff  <= record_length_in;
         record_address_ff <= record_address_in;
         high_nibble_ff    <= high_nibble_in;
         bytes_done_ff     <= bytes_done_in;
         finished_ff       <= finished_in;
      end
   end

   // result register: loads on a new result, clears when the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_address_ff <= emit_address;
         rsp_data_ff    <= emit_data;
         rsp_end_ff     <= emit_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_address_ff;
   assign rsp_write_data    = rsp_data_ff;
   assign rsp_is_end        = rsp_end_ff;

endmodule

`default_nettype wire

[sv/hrl_checker.sv]
// hrl_checker: port level checks on the hex record loader and its bind
// depends on hex_record_loader ports only
`timescale 1ns / 1ps
`default_nettype none

module hrl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_write_address,
   input wire logic [7:0]  rsp_write_data,
   input wire logic        rsp_is_end
);

   logic end_seen_ff;

   // remember that the end marker transfer has completed
   always_ff @(posedge clock) begin
      if (reset) begin
         end_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_is_end) begin
         end_seen_ff <= 1'b1;
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_address)
         && $stable(rsp_write_data) && $stable(rsp_is_end))
      else $error("stalled result changed");

   // nothing follows the end marker
   assert property (@(posedge clock) disable iff (reset)
      end_seen_ff |-> !rsp_valid)
      else $error("result after end marker");

   // end marker carries zero address and data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_write_address == 16'd0 && rsp_write_data == 8'd0)
      else $error("end marker with nonzero payload");

   // no result in the first cycle out of reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_address (rsp_write_address),
   .rsp_write_data    (rsp_write_data),
   .rsp_is_end        (rsp_is_end)
);

`default_nettype wire
